// ===== hw/rtl/scm_pkg.sv =====
// ----------------------------------------------------------------------------
// Colormap package
// Shared codes and coefficient tables for the scalar colormap block.
// ----------------------------------------------------------------------------
`default_nettype none

package scm_pkg;

  localparam logic [2:0] MAP_VIRIDIS = 3'd0;
  localparam logic [2:0] MAP_PLASMA  = 3'd1;
  localparam logic [2:0] MAP_HOT     = 3'd2;
  localparam logic [2:0] MAP_COOL    = 3'd3;
  localparam logic [2:0] MAP_GRAY    = 3'd4;

  localparam logic [1:0] REG_SELECT = 2'd0;
  localparam logic [1:0] REG_LOW    = 2'd1;
  localparam logic [1:0] REG_HIGH   = 2'd2;

  localparam int MICRO = 1000000;

  // Coefficient in millionths; map 0 viridis, 1 plasma; channel; power.
  function automatic logic signed [23:0] coef(input logic map, input logic [1:0] ch,
                                              input logic [1:0] k);
    logic signed [23:0] v;
    v = 24'sd0;
    if (!map) begin
      case ({ch, k})
        4'h0: v = 24'sd267004;  4'h1: v = 24'sd127568;
        4'h2: v = -24'sd24876;  4'h3: v = 24'sd579829;
        4'h4: v = 24'sd4874;    4'h5: v = 24'sd464034;
        4'h6: v = 24'sd513925;  4'h7: v = 24'sd15556;
        4'h8: v = 24'sd329415;  4'h9: v = 24'sd751663;
        4'hA: v = -24'sd486213; 4'hB: v = 24'sd215770;
        default: v = 24'sd0;
      endcase
    end else begin
      case ({ch, k})
        4'h0: v = 24'sd50383;    4'h1: v = 24'sd508010;
        4'h2: v = 24'sd434154;   4'h3: v = 24'sd25556;
        4'h4: v = 24'sd29873;    4'h5: v = 24'sd396;
        4'h6: v = 24'sd1336863;  4'h7: v = -24'sd328552;
        4'h8: v = 24'sd527975;   4'h9: v = 24'sd612328;
        4'hA: v = -24'sd1088060; 4'hB: v = 24'sd43675;
        default: v = 24'sd0;
      endcase
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/scm_norm.sv =====
// ----------------------------------------------------------------------------
// Colormap normalizer
// Pipelined restoring divider giving t = (sample - low) / (high - low) in
// Q1.FRAC_BITS, one quotient bit per stage, clamped and rounded.
// ----------------------------------------------------------------------------
`default_nettype none

module scm_norm #(
  parameter int FRAC_BITS    = 16,
  parameter int SAMPLE_WIDTH = 32,
  parameter int TAG_WIDTH    = 3
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire logic                    in_valid,
  input  wire logic [SAMPLE_WIDTH-1:0] sample,
  input  wire logic [SAMPLE_WIDTH-1:0] range_low,
  input  wire logic [SAMPLE_WIDTH-1:0] range_high,
  input  wire logic [TAG_WIDTH-1:0]    in_tag,
  output logic                         out_valid,
  output logic [FRAC_BITS:0]           t,
  output logic [TAG_WIDTH-1:0]         out_tag
);

  localparam int DW = SAMPLE_WIDTH + 1;
  localparam int QB = FRAC_BITS + 1;
  localparam int ST = QB + 2;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [ST-1:0]          vld;
  logic [DW:0]            rem [QB+1];
  logic [DW-1:0]          den [QB+1];
  logic [QB-1:0]          quo [QB+1];
  logic [1:0]             fix [QB+1];
  logic [TAG_WIDTH-1:0]   tag [ST];

  logic signed [DW-1:0] d0, n0, ad, an;
  logic [1:0]           fix0;

  always_comb begin
    d0 = $signed({range_high[SAMPLE_WIDTH-1], range_high})
       - $signed({range_low[SAMPLE_WIDTH-1], range_low});
    n0 = $signed({sample[SAMPLE_WIDTH-1], sample})
       - $signed({range_low[SAMPLE_WIDTH-1], range_low});
    ad = d0[DW-1] ? -d0 : d0;
    an = d0[DW-1] ? -n0 : n0;
    fix0 = 2'd0;
    if (d0 == '0) begin
      fix0 = n0[DW-1] ? 2'd1 : 2'd2;
    end else if (an[DW-1] || an == '0) begin
      fix0 = 2'd1;
    end else if (an >= ad) begin
      fix0 = 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[ST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= {1'b0, an};
      den[0] <= ad;
      quo[0] <= '0;
      fix[0] <= fix0;
      tag[0] <= in_tag;
    end
  end

  for (genvar i = 1; i <= QB; i++) begin : g_div
    logic [DW:0] sh;
    assign sh = {rem[i-1][DW-1:0], 1'b0};
    always_ff @(posedge clk) begin
      if (en) begin
        den[i] <= den[i-1];
        fix[i] <= fix[i-1];
        tag[i] <= tag[i-1];
        if (sh >= {1'b0, den[i-1]}) begin
          rem[i] <= sh - {1'b0, den[i-1]};
          quo[i] <= {quo[i-1][QB-2:0], 1'b1};
        end else begin
          rem[i] <= sh;
          quo[i] <= {quo[i-1][QB-2:0], 1'b0};
        end
      end
    end
  end

  logic [QB:0] rnd;
  assign rnd = {1'b0, quo[QB]} + {{QB{1'b0}}, 1'b1};

  always_ff @(posedge clk) begin
    if (en) begin
      tag[ST-1] <= tag[QB];
      case (fix[QB])
        2'd1:    t <= '0;
        2'd2:    t <= ONE;
        default: t <= rnd[QB:1];
      endcase
    end
  end

  assign out_valid = vld[ST-1];
  assign out_tag   = tag[ST-1];

endmodule

`default_nettype wire

// ===== hw/rtl/scm_map.sv =====
// ----------------------------------------------------------------------------
// Colormap mapper
// Maps t to RGB: Horner polynomials over three multiply stages, then
// clamp and millionths conversion, with the simple maps carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module scm_map #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [2:0]       sel,
  input  wire logic [FRAC_BITS:0] t,
  output logic                  out_valid,
  output logic [FRAC_BITS:0]    red,
  output logic [FRAC_BITS:0]    green,
  output logic [FRAC_BITS:0]    blue
);
  import scm_pkg::*;

  localparam int OW = FRAC_BITS + 1;
  localparam int AW = 26;
  localparam int PW = AW + OW + 1;
  localparam int MW = FRAC_BITS + 14;
  localparam int RK = MW + 14;
  localparam int RW = RK - 13;
  localparam longint RECIP = ((64'sd1 <<< RK) + 64'sd15624) / 64'sd15625;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam int ST = 6;

  logic [ST-1:0]       vld;
  logic [2:0]          sl  [ST-1];
  logic [FRAC_BITS:0]  tt  [ST-1];
  logic signed [AW-1:0] acc [4][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[ST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sl[0] <= sel;
      tt[0] <= t;
      for (int c = 0; c < 3; c++) begin
        acc[0][c] <= AW'(coef(sel == MAP_PLASMA, 2'(c), 2'd3));
      end
    end
  end

  for (genvar s = 1; s <= 3; s++) begin : g_horner
    for (genvar c = 0; c < 3; c++) begin : g_ch
      logic signed [PW-1:0] p;
      logic signed [PW-1:0] q;
      assign p = acc[s-1][c] * $signed({1'b0, tt[s-1]});
      assign q = (p + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      always_ff @(posedge clk) begin
        if (en) begin
          acc[s][c] <= AW'(q) + AW'(coef(sl[s-1] == MAP_PLASMA, 2'(c), 2'(3 - s)));
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sl[s] <= sl[s-1];
        tt[s] <= tt[s-1];
      end
    end
  end

  // Division by one million is a shift by six followed by a reciprocal
  // multiply for 15625.
  logic [MW-1:0] num [3];
  logic [1:0]    cl  [3];

  always_ff @(posedge clk) begin
    if (en) begin
      sl[4] <= sl[3];
      tt[4] <= tt[3];
      for (int c = 0; c < 3; c++) begin
        cl[c] <= {acc[3][c] <= 0, acc[3][c] >= AW'(MICRO)};
        num[c] <= (MW'(acc[3][c][19:0]) << (FRAC_BITS - 6)) + MW'(MICRO / 128);
      end
    end
  end

  logic [MW+RW-1:0]     prod [3];
  logic [FRAC_BITS:0]   pv [3];
  logic [FRAC_BITS+2:0] t3;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = (MW+RW)'(num[c]) * (MW+RW)'(RECIP);
      if (cl[c][1])      pv[c] = '0;
      else if (cl[c][0]) pv[c] = ONE;
      else               pv[c] = OW'(prod[c] >> RK);
    end
    t3 = {2'b0, tt[4]} + {1'b0, tt[4], 1'b0};
  end

  function automatic logic [FRAC_BITS:0] clampu(input logic [FRAC_BITS+2:0] v,
                                                input logic [FRAC_BITS+2:0] off);
    if (v <= off) return '0;
    if (v - off >= {2'b0, ONE}) return ONE;
    return OW'(v - off);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      case (sl[4])
        MAP_VIRIDIS, MAP_PLASMA: begin
          red <= pv[0]; green <= pv[1]; blue <= pv[2];
        end
        MAP_HOT: begin
          red   <= clampu(t3, '0);
          green <= clampu(t3, {2'b0, ONE});
          blue  <= clampu(t3, {1'b0, ONE, 1'b0});
        end
        MAP_COOL: begin
          red <= tt[4]; green <= ONE - tt[4]; blue <= ONE;
        end
        default: begin
          red <= tt[4]; green <= tt[4]; blue <= tt[4];
        end
      endcase
    end
  end

  assign out_valid = vld[ST-1];

endmodule

`default_nettype wire

// ===== hw/rtl/scalar_colormap_rgb.sv =====
// Throughput: one sample per cycle while the output is not stalled;
// the divider has one stage per quotient bit.
// Backpressure stalls the whole pipeline; a stall loses nothing.
// Reset (rst, synchronous) empties the pipeline and sets viridis, range 0..1.0.
// ----------------------------------------------------------------------------
// Scalar colormap top level
// Normalizes a fixed-point sample against a range and maps it to RGB.
// ----------------------------------------------------------------------------
`default_nettype none

module scalar_colormap_rgb #(
  parameter int FRAC_BITS    = 16,
  parameter int SAMPLE_WIDTH = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic [1:0]              cfg_index,
  input  wire logic [SAMPLE_WIDTH-1:0] cfg_data,
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,  // sample
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  output logic [((3*(FRAC_BITS+1)+7)/8)*8-1:0] m_tdata  // red, green, blue
);
  import scm_pkg::*;

  localparam int OW  = FRAC_BITS + 1;
  localparam int MOW = ((3 * OW + 7) / 8) * 8;

  logic [2:0]              sel;
  logic [SAMPLE_WIDTH-1:0] lo, hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= MAP_VIRIDIS;
      lo  <= '0;
      hi  <= SAMPLE_WIDTH'(1) << FRAC_BITS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SELECT: sel <= cfg_data[2:0];
        REG_LOW:    lo  <= cfg_data;
        REG_HIGH:   hi  <= cfg_data;
        default:    ;
      endcase
    end
  end

  logic en, nv, mv;
  logic [FRAC_BITS:0] t, r, g, b;
  logic [2:0] nsel;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  scm_norm #(.FRAC_BITS(FRAC_BITS), .SAMPLE_WIDTH(SAMPLE_WIDTH), .TAG_WIDTH(3)) u_norm (
    .clk, .rst, .en, .in_valid(s_tvalid), .sample(s_tdata[SAMPLE_WIDTH-1:0]),
    .range_low(lo), .range_high(hi), .in_tag(sel),
    .out_valid(nv), .t(t), .out_tag(nsel)
  );

  scm_map #(.FRAC_BITS(FRAC_BITS)) u_map (
    .clk, .rst, .en, .in_valid(nv), .sel(nsel), .t(t),
    .out_valid(mv), .red(r), .green(g), .blue(b)
  );

  assign m_tvalid = mv;
  assign m_tdata  = MOW'({b, g, r});

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (r <= (OW'(1) << FRAC_BITS) && g <= (OW'(1) << FRAC_BITS)
                  && b <= (OW'(1) << FRAC_BITS)))
    else $error("channel above one");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("accepting while stalled");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata))
    else $error("output changed during stall");

endmodule

`default_nettype wire
